// ===== design/kcs_pkg.sv =====
package kcs_pkg;

    localparam int DATA_W = 32;
    localparam int K_W    = 7;

    localparam logic [K_W-1:0] RESULT_LIMIT = 7'd64;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HI,
        S_HI_CHK,
        S_LO_CHK,
        S_MID_CHK,
        S_MID1_CHK,
        S_SETUP,
        S_LREQ,
        S_LGET,
        S_RREQ,
        S_RGET,
        S_EMIT
    } t_state;

endpackage

// ===== design/kcs_store.sv =====
module kcs_store #(
    parameter int DEPTH = 64,
    parameter int IW    = 6
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [IW-1:0]             i_waddr,
    input  logic [kcs_pkg::DATA_W-1:0] i_wdata,
    input  logic [IW-1:0]             i_raddr,
    output logic [kcs_pkg::DATA_W-1:0] o_rdata
);
    import kcs_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/k_closest_sorted_select.sv =====
// channel   | valid    | ready    | payload
// ----------+----------+----------+------------------------------------------------
// request   | i_valid  | o_ready  | i_func, i_elem_value, i_query_target, i_want_count
// result    | o_valid  | i_ready  | o_near_value, o_last_flag
//
// a load request is taken without leaving S_IDLE; loads may arrive back to back
// a query with elements loaded and a nonzero count holds o_ready low through the
// binary search steps (one memory read port, registered read data), setup and first
// fetches, then the emit, read and capture of each result, plus any output stall
// reset clears the element count and the closed flag; memory contents are not cleared
// a stalled result holds in the output register; next fetch runs, then S_EMIT waits
module k_closest_sorted_select #(
    parameter int MAX_ELEMS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_func,
    input  logic signed [kcs_pkg::DATA_W-1:0] i_elem_value,
    input  logic signed [kcs_pkg::DATA_W-1:0] i_query_target,
    input  logic [kcs_pkg::K_W-1:0]     i_want_count,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [kcs_pkg::DATA_W-1:0] o_near_value,
    output logic                        o_last_flag
);
    import kcs_pkg::*;

    localparam int IW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
    localparam int CW = $clog2(MAX_ELEMS + 1);
    localparam int AW = CW + 1;
    localparam int SW = (AW > K_W) ? AW : K_W;

    t_state r_state, n_state;

    logic [CW-1:0]             r_count, n_count;
    logic                      r_closed, n_closed;
    logic [IW-1:0]             r_lo, n_lo;
    logic [IW-1:0]             r_hi, n_hi;
    logic signed [DATA_W-1:0]  r_x, n_x;
    logic [K_W-1:0]            r_rem, n_rem;
    logic [CW-1:0]             r_lcnt, n_lcnt;
    logic [CW-1:0]             r_r, n_r;
    logic signed [DATA_W-1:0]  r_lval, n_lval;
    logic signed [DATA_W-1:0]  r_rval, n_rval;
    logic                      r_init, n_init;
    logic                      r_oval, n_oval;
    logic signed [DATA_W-1:0]  r_onear, n_onear;
    logic                      r_olast, n_olast;

    logic                      we;
    logic [IW-1:0]             waddr;
    logic [IW-1:0]             raddr;
    logic signed [DATA_W-1:0]  rdata;

    logic [IW:0]               sum_lohi;
    logic [IW-1:0]             mid;
    logic [IW-1:0]             mid_p1;
    logic                      found;
    logic [IW-1:0]             found_idx;
    logic signed [DATA_W-1:0]  found_val;
    logic [K_W-1:0]            k_clamp;
    logic [SW-1:0]             avail;
    logic [SW-1:0]             total;
    logic                      have_l;
    logic                      have_r;
    logic signed [DATA_W:0]    dist_l;
    logic signed [DATA_W:0]    dist_r;
    logic                      take_l;
    logic                      out_free;

    kcs_store #(
        .DEPTH (MAX_ELEMS),
        .IW    (IW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_elem_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign sum_lohi = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid      = sum_lohi[IW:1];
    assign mid_p1   = mid + 1'b1;
    assign k_clamp  = (i_want_count > RESULT_LIMIT) ? RESULT_LIMIT : i_want_count;
    assign avail    = SW'(r_lcnt) + SW'(r_count) - SW'(r_r);
    assign total    = (SW'(r_rem) < avail) ? SW'(r_rem) : avail;
    assign have_l   = (r_lcnt != '0);
    assign have_r   = (r_r < r_count);
    assign dist_l   = {r_x[DATA_W-1], r_x} - {r_lval[DATA_W-1], r_lval};
    assign dist_r   = {r_rval[DATA_W-1], r_rval} - {r_x[DATA_W-1], r_x};
    assign take_l   = have_l && (!have_r || (dist_l < dist_r));
    assign out_free = !r_oval || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_closed <= 1'b0;
            r_oval   <= 1'b0;
            r_init   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_closed <= n_closed;
            r_oval   <= n_oval;
            r_init   <= n_init;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_x     <= n_x;
        r_rem   <= n_rem;
        r_lcnt  <= n_lcnt;
        r_r     <= n_r;
        r_lval  <= n_lval;
        r_rval  <= n_rval;
        r_onear <= n_onear;
        r_olast <= n_olast;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_closed  = r_closed;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_x       = r_x;
        n_rem     = r_rem;
        n_lcnt    = r_lcnt;
        n_r       = r_r;
        n_lval    = r_lval;
        n_rval    = r_rval;
        n_init    = r_init;
        n_oval    = r_oval && !i_ready;
        n_onear   = r_onear;
        n_olast   = r_olast;
        we        = 1'b0;
        waddr     = r_count[IW-1:0];
        raddr     = '0;
        found     = 1'b0;
        found_idx = r_hi;
        found_val = rdata;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_func == FUNC_LOAD) begin
                        if (r_closed) begin
                            we       = 1'b1;
                            waddr    = '0;
                            n_count  = CW'(1);
                            n_closed = 1'b0;
                        end else if (r_count < CW'(MAX_ELEMS)) begin
                            we      = 1'b1;
                            n_count = r_count + 1'b1;
                        end
                    end else begin
                        n_closed = 1'b1;
                        n_x      = i_query_target;
                        n_rem    = k_clamp;
                        n_lo     = '0;
                        n_hi     = IW'(r_count - 1'b1);
                        if (r_count != '0 && k_clamp != '0) begin
                            n_state = S_HI;
                        end
                    end
                end
            end
            S_HI: begin
                raddr   = r_hi;
                n_state = S_HI_CHK;
            end
            S_HI_CHK: begin
                if (rdata <= r_x) begin
                    found     = 1'b1;
                    found_idx = r_hi;
                end else begin
                    raddr   = r_lo;
                    n_state = S_LO_CHK;
                end
            end
            S_LO_CHK: begin
                if (rdata > r_x) begin
                    found     = 1'b1;
                    found_idx = r_lo;
                end else begin
                    raddr   = mid;
                    n_state = S_MID_CHK;
                end
            end
            S_MID_CHK: begin
                n_lval = rdata;
                if (rdata <= r_x) begin
                    raddr   = mid_p1;
                    n_state = S_MID1_CHK;
                end else begin
                    n_hi    = mid - 1'b1;
                    n_state = S_HI;
                end
            end
            S_MID1_CHK: begin
                if (rdata > r_x) begin
                    found     = 1'b1;
                    found_idx = mid;
                    found_val = r_lval;
                end else if (r_lval < r_x) begin
                    n_lo    = mid_p1;
                    n_state = S_HI;
                end else begin
                    n_hi    = mid - 1'b1;
                    n_state = S_HI;
                end
            end
            S_SETUP: begin
                if (total == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_rem   = K_W'(total);
                    n_state = r_init ? S_LREQ : S_RREQ;
                end
            end
            S_LREQ: begin
                if (have_l) begin
                    raddr   = IW'(r_lcnt - 1'b1);
                    n_state = S_LGET;
                end else begin
                    n_init  = 1'b0;
                    n_state = r_init ? S_RREQ : S_EMIT;
                end
            end
            S_LGET: begin
                n_lval  = rdata;
                n_init  = 1'b0;
                n_state = r_init ? S_RREQ : S_EMIT;
            end
            S_RREQ: begin
                if (have_r) begin
                    raddr   = r_r[IW-1:0];
                    n_state = S_RGET;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_RGET: begin
                n_rval  = rdata;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_oval  = 1'b1;
                    n_olast = (r_rem == K_W'(1));
                    n_rem   = r_rem - 1'b1;
                    if (take_l) begin
                        n_onear = r_lval;
                        n_lcnt  = r_lcnt - 1'b1;
                    end else begin
                        n_onear = r_rval;
                        n_r     = r_r + 1'b1;
                    end
                    if (r_rem == K_W'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = take_l ? S_LREQ : S_RREQ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // crossover found: right starts just past it; left at it, or below it if it equals the target
        if (found) begin
            n_r     = CW'(found_idx) + 1'b1;
            n_lval  = found_val;
            n_init  = (found_val == r_x);
            n_lcnt  = (found_val == r_x) ? CW'(found_idx) : CW'(found_idx) + 1'b1;
            n_state = S_SETUP;
        end
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_oval;
    assign o_near_value = r_onear;
    assign o_last_flag  = r_olast;

endmodule

// ===== design/kcs_check.sv =====
module kcs_check (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_ready,
    input logic                         i_func,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic [kcs_pkg::DATA_W-1:0]   o_near_value,
    input logic                         o_last_flag
);
    import kcs_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_near_value) && $stable(o_last_flag))
        else $error("result changed under stall");

    // results only come out of a running query
    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !$past(o_ready))
        else $error("result appeared while idle");

    // a load never holds off the next request
    a_load_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_func == FUNC_LOAD) |=> o_ready)
        else $error("load stalled the request side");

    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind k_closest_sorted_select kcs_check u_kcs_check (.*);
